FILE: hdl/flow_rate_limit_syn_flood_detector_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef FLOW_RATE_LIMIT_SYN_FLOOD_DETECTOR_UNIT_ASSERT_SVH
`define FLOW_RATE_LIMIT_SYN_FLOOD_DETECTOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FRL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/frl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package frl_pkg;

    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 63;

    localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_WINDOW = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYN_RATIO   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYN_MINIMUM = 8'd3;

    localparam logic [31:0] RATE_LIMIT_RST  = 32'd100;
    localparam logic [62:0] TIME_WINDOW_RST = 63'd1_000_000_000;
    localparam logic [7:0]  SYN_RATIO_RST   = 8'd3;
    localparam logic [31:0] SYN_MINIMUM_RST = 32'd50;

    localparam logic [1:0] KIND_SYN    = 2'd0;
    localparam logic [1:0] KIND_SYNACK = 2'd1;

    localparam logic [10:0] ATT_MAX = 11'd2047;

    typedef struct packed {
        logic        valid;
        logic        mark;
        logic [31:0] tag;
        logic [31:0] count;
        logic [62:0] start;
    } t_src_entry;

    typedef struct packed {
        logic        valid;
        logic [31:0] tag;
        logic [31:0] syn;
        logic [31:0] ack;
    } t_dst_entry;

endpackage

`default_nettype wire

FILE: hdl/frl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module frl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/frl_hash.sv
`timescale 1ns / 1ps
`default_nettype none

module frl_hash #(
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [31:0]   i_addr,
    output logic               o_valid,
    output logic      [AW-1:0] o_index
);

    // Remainder by the table depth through a rounded-up reciprocal; the
    // estimate is exact for every 16-bit dividend.
    localparam logic [32:0] RECIP =
        33'(((64'd1 << 32) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

    logic        r_v1, r_v2, r_v3;
    logic [31:0] r_h;
    logic [15:0] r_val;
    logic [15:0] r_q;
    logic [AW-1:0] r_idx;
    logic [48:0] w_qprod;
    logic [32:0] w_qd;
    logic [32:0] w_rem;

    assign w_qprod = 49'(r_h[31:16]) * 49'(RECIP);
    assign w_qd    = 33'(r_q) * 33'(DEPTH);
    assign w_rem   = 33'(r_val) - w_qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_h   <= 32'(i_addr * frl_pkg::HASH_MULT);
        r_val <= r_h[31:16];
        r_q   <= w_qprod[47:32];
        r_idx <= w_rem[AW-1:0];
    end

    assign o_valid = r_v3;
    assign o_index = r_idx;

endmodule

`default_nettype wire

FILE: hdl/flow_rate_limit_syn_flood_detector_unit.sv
// One packet is in flight at a time: input is taken only in ST_IDLE, and each packet
// passes the 3-stage hash, the registered table read and the two evaluate stages
// before write-back in ST_DONE, which waits while the result output is stalled.
// Reset: synchronous, active low; config returns to its defaults, then a
// clearing pass over max(SOURCE_ENTRIES, DEST_ENTRIES) addresses empties both tables.
`timescale 1ns / 1ps
`default_nettype none

module flow_rate_limit_syn_flood_detector_unit #(
    parameter int SOURCE_ENTRIES = 1024,
    parameter int DEST_ENTRIES   = 256
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // source_address[31:0], dest_address[63:32], timestamp_ns[126:64], zero[127]
    input  wire logic [127:0] i_s_axis_tdata,
    // tcp_kind[1:0]
    input  wire logic [1:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // over_limit[0], new_attacker[1], attacker_total[12:2], syn_flood[13],
    // syn_total[45:14], synack_total[77:46], untracked[78], zero[79]
    output logic      [79:0]  o_m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [frl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [frl_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int SRC_AW = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;
    localparam int DST_AW = (DEST_ENTRIES > 1) ? $clog2(DEST_ENTRIES) : 1;
    localparam int CLR_DEPTH = (SOURCE_ENTRIES > DEST_ENTRIES) ? SOURCE_ENTRIES
                                                                : DEST_ENTRIES;
    localparam int CLR_AW = $clog2(CLR_DEPTH);
    localparam int SRC_W = $bits(frl_pkg::t_src_entry);
    localparam int DST_W = $bits(frl_pkg::t_dst_entry);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_HASH, ST_READ, ST_EVAL, ST_DONE
    } t_state;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    t_state r_state;

    logic [31:0] r_rate_limit;
    logic [62:0] r_time_window;
    logic [7:0]  r_syn_ratio;
    logic [31:0] r_syn_minimum;

    logic [CLR_AW-1:0] r_clr_cnt;
    logic [10:0]       r_att;
    logic              r_m_tvalid;
    logic [79:0]       r_m_tdata;

    logic [31:0] r_src, r_dst;
    logic [62:0] r_ts;
    logic [1:0]  r_kind;
    logic [SRC_AW-1:0] r_src_idx;
    logic [DST_AW-1:0] r_dst_idx;

    logic        r_dst_use, r_dst_coll;
    logic [31:0] r_syn_new, r_ack_new;
    logic        r_src_coll, r_src_check, r_mark_old;
    logic [31:0] r_cnt_new;
    logic [62:0] r_start_new;
    logic [39:0] r_prod;
    logic        r_over, r_syn_gt_min;

    logic              w_accept;
    logic              w_src_hv, w_dst_hv;
    logic [SRC_AW-1:0] w_src_idx;
    logic [DST_AW-1:0] w_dst_idx;
    logic [SRC_W-1:0]  w_src_rdata;
    logic [DST_W-1:0]  w_dst_rdata;
    frl_pkg::t_src_entry w_src_e, w_src_wr;
    frl_pkg::t_dst_entry w_dst_e, w_dst_wr;

    logic        w_counts, w_dst_hit, w_dst_claim, w_dst_coll;
    logic [31:0] w_syn_base, w_ack_base, w_ack_one;
    logic        w_src_claim, w_src_hit, w_src_coll, w_inside;
    logic [62:0] w_ts_diff;
    logic        w_commit, w_flood, w_fresh;
    logic [10:0] n_att;
    logic        w_clr_last;

    logic              w_src_we, w_dst_we;
    logic [SRC_AW-1:0] w_src_waddr;
    logic [DST_AW-1:0] w_dst_waddr;
    logic [SRC_W-1:0]  w_src_wdata;
    logic [DST_W-1:0]  w_dst_wdata;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    frl_hash #(.DEPTH(SOURCE_ENTRIES)) u_src_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_addr  (i_s_axis_tdata[31:0]),
        .o_valid (w_src_hv),
        .o_index (w_src_idx)
    );

    frl_hash #(.DEPTH(DEST_ENTRIES)) u_dst_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_addr  (i_s_axis_tdata[63:32]),
        .o_valid (w_dst_hv),
        .o_index (w_dst_idx)
    );

    // Table lookup decisions, valid while in ST_READ.
    assign w_src_e = frl_pkg::t_src_entry'(w_src_rdata);
    assign w_dst_e = frl_pkg::t_dst_entry'(w_dst_rdata);

    assign w_counts    = (r_kind == frl_pkg::KIND_SYN) || (r_kind == frl_pkg::KIND_SYNACK);
    assign w_dst_hit   = w_dst_e.valid && (w_dst_e.tag == r_dst);
    assign w_dst_claim = !w_dst_e.valid && w_counts;
    assign w_dst_coll  = w_dst_e.valid && (w_dst_e.tag != r_dst);
    assign w_syn_base  = w_dst_claim ? 32'd0 : w_dst_e.syn;
    assign w_ack_base  = w_dst_claim ? 32'd0 : w_dst_e.ack;

    assign w_src_claim = !w_src_e.valid;
    assign w_src_hit   = w_src_e.valid && (w_src_e.tag == r_src);
    assign w_src_coll  = w_src_e.valid && (w_src_e.tag != r_src);
    assign w_ts_diff   = r_ts - w_src_e.start;
    assign w_inside    = (r_ts < w_src_e.start) || (w_ts_diff < r_time_window);

    assign w_ack_one = (r_ack_new == 32'd0) ? 32'd1 : r_ack_new;

    // Final decision and write-back in ST_DONE.
    assign w_commit   = (r_state == ST_DONE) && (!r_m_tvalid || i_m_axis_tready);
    assign w_flood    = r_dst_use && r_syn_gt_min && ({8'd0, r_syn_new} > r_prod);
    assign w_fresh    = r_over && !r_mark_old;
    assign n_att      = (w_fresh && (r_att != frl_pkg::ATT_MAX)) ? r_att + 11'd1 : r_att;
    assign w_clr_last = (r_clr_cnt == CLR_AW'(CLR_DEPTH - 1));

    always_comb begin
        w_src_wr       = '0;
        w_src_wr.valid = 1'b1;
        w_src_wr.mark  = r_mark_old || r_over;
        w_src_wr.tag   = r_src;
        w_src_wr.count = r_cnt_new;
        w_src_wr.start = r_start_new;
        w_dst_wr       = '0;
        w_dst_wr.valid = 1'b1;
        w_dst_wr.tag   = r_dst;
        w_dst_wr.syn   = r_syn_new;
        w_dst_wr.ack   = r_ack_new;
    end

    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_src_we    = ({1'b0, r_clr_cnt} < (CLR_AW + 1)'(SOURCE_ENTRIES));
            w_dst_we    = ({1'b0, r_clr_cnt} < (CLR_AW + 1)'(DEST_ENTRIES));
            w_src_waddr = r_clr_cnt[SRC_AW-1:0];
            w_dst_waddr = r_clr_cnt[DST_AW-1:0];
            w_src_wdata = '0;
            w_dst_wdata = '0;
        end else begin
            w_src_we    = w_commit && !r_src_coll;
            w_dst_we    = w_commit && r_dst_use;
            w_src_waddr = r_src_idx;
            w_dst_waddr = r_dst_idx;
            w_src_wdata = w_src_wr;
            w_dst_wdata = w_dst_wr;
        end
    end

    frl_ram #(.WIDTH(SRC_W), .DEPTH(SOURCE_ENTRIES)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (w_src_we),
        .i_waddr (w_src_waddr),
        .i_wdata (w_src_wdata),
        .i_re    (w_src_hv),
        .i_raddr (w_src_idx),
        .o_rdata (w_src_rdata)
    );

    frl_ram #(.WIDTH(DST_W), .DEPTH(DEST_ENTRIES)) u_dst_ram (
        .i_clk   (i_clk),
        .i_we    (w_dst_we),
        .i_waddr (w_dst_waddr),
        .i_wdata (w_dst_wdata),
        .i_re    (w_dst_hv),
        .i_raddr (w_dst_idx),
        .o_rdata (w_dst_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_cnt     <= '0;
            r_att         <= '0;
            r_m_tvalid    <= 1'b0;
            r_rate_limit  <= frl_pkg::RATE_LIMIT_RST;
            r_time_window <= frl_pkg::TIME_WINDOW_RST;
            r_syn_ratio   <= frl_pkg::SYN_RATIO_RST;
            r_syn_minimum <= frl_pkg::SYN_MINIMUM_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    frl_pkg::REG_RATE_LIMIT:  r_rate_limit  <= i_cfg_wdata[31:0];
                    frl_pkg::REG_TIME_WINDOW: r_time_window <= i_cfg_wdata;
                    frl_pkg::REG_SYN_RATIO:   r_syn_ratio   <= i_cfg_wdata[7:0];
                    frl_pkg::REG_SYN_MINIMUM: r_syn_minimum <= i_cfg_wdata[31:0];
                    default: ;
                endcase
            end

            if (w_commit) begin
                r_m_tvalid <= 1'b1;
            end else if (r_m_tvalid && i_m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + CLR_AW'(1);
                    if (w_clr_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_src   <= i_s_axis_tdata[31:0];
                        r_dst   <= i_s_axis_tdata[63:32];
                        r_ts    <= i_s_axis_tdata[126:64];
                        r_kind  <= i_s_axis_tuser;
                        r_state <= ST_HASH;
                    end
                end
                ST_HASH: begin
                    if (w_src_hv) begin
                        r_src_idx <= w_src_idx;
                        r_dst_idx <= w_dst_idx;
                        r_state   <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_dst_use  <= w_dst_hit || w_dst_claim;
                    r_dst_coll <= w_dst_coll;
                    r_syn_new  <= (r_kind == frl_pkg::KIND_SYN) ? sat_inc32(w_syn_base)
                                                               : w_syn_base;
                    r_ack_new  <= (r_kind == frl_pkg::KIND_SYNACK) ? sat_inc32(w_ack_base)
                                                                  : w_ack_base;
                    r_src_coll  <= w_src_coll;
                    r_src_check <= w_src_hit && w_inside;
                    r_mark_old  <= w_src_e.valid && w_src_e.mark;
                    r_cnt_new   <= (w_src_hit && w_inside) ? sat_inc32(w_src_e.count)
                                                           : 32'd1;
                    r_start_new <= (w_src_hit && w_inside) ? w_src_e.start : r_ts;
                    r_state     <= ST_EVAL;
                end
                ST_EVAL: begin
                    r_prod       <= 40'(r_syn_ratio) * 40'(w_ack_one);
                    r_over       <= r_src_check && (r_cnt_new > r_rate_limit);
                    r_syn_gt_min <= r_syn_new > r_syn_minimum;
                    r_state      <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_commit) begin
                        r_att      <= n_att;
                        r_m_tdata  <= {1'b0,
                                       r_dst_coll || r_src_coll,
                                       r_dst_use ? r_ack_new : 32'd0,
                                       r_dst_use ? r_syn_new : 32'd0,
                                       w_flood,
                                       n_att,
                                       w_fresh,
                                       r_over};
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;

endmodule

`default_nettype wire

FILE: hdl/frl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "flow_rate_limit_syn_flood_detector_unit_assert.svh"

module frl_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [79:0]  o_m_axis_tdata
);

    `FRL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "Result beat dropped while stalled.")
    `FRL_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata), "Result beat changed while stalled.")
    `FRL_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "Input taken while a packet is in flight.")
    `FRL_ASSERT_SAME(a_fresh_over, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[1], o_m_axis_tdata[0], "New attacker without over limit.")
    `FRL_ASSERT_SAME(a_flood_syn, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[13], o_m_axis_tdata[45:14] != 32'd0, "SYN flood with zero SYN count.")

endmodule

bind flow_rate_limit_syn_flood_detector_unit frl_checker u_frl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

FILE: verif/flow_rate_limit_syn_flood_detector_unit_tb.sv
`timescale 1ns / 1ps

module flow_rate_limit_syn_flood_detector_unit_tb;

    localparam int SRC_DEPTH = 1024;
    localparam int DST_DEPTH = 256;
    localparam int SRC_POOL = 12;
    localparam int DST_POOL = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [1:0] KIND_ACK   = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;
    localparam logic [62:0] TS_MAX = {63{1'b1}};

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [62:0] ts;
        logic [1:0]  kind;
    } t_packet;

    typedef struct packed {
        logic        over;
        logic        fresh;
        logic [10:0] total;
        logic        flood;
        logic [31:0] syn;
        logic [31:0] ack;
        logic        untracked;
    } t_verdict;

    typedef struct {
        t_packet  pkt;
        bit       literal;
        t_verdict want;
    } t_dir_row;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tready = 1'b0;
    logic         cfg_we = 1'b0;
    logic [frl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [frl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    wire          s_tready;
    wire          m_tvalid;
    wire  [79:0]  m_tdata;

    flow_rate_limit_syn_flood_detector_unit #(
        .SOURCE_ENTRIES(SRC_DEPTH),
        .DEST_ENTRIES  (DST_DEPTH)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Predictor copy of the configuration and of both tables.
    logic [31:0] lim_rate   = frl_pkg::RATE_LIMIT_RST;
    logic [62:0] lim_window = frl_pkg::TIME_WINDOW_RST;
    logic [7:0]  lim_ratio  = frl_pkg::SYN_RATIO_RST;
    logic [31:0] lim_min    = frl_pkg::SYN_MINIMUM_RST;

    bit          src_used    [SRC_DEPTH];
    logic [31:0] src_owner   [SRC_DEPTH];
    logic [31:0] src_hits    [SRC_DEPTH];
    logic [62:0] src_since   [SRC_DEPTH];
    bit          src_flagged [SRC_DEPTH];
    bit          dst_used    [DST_DEPTH];
    logic [31:0] dst_owner   [DST_DEPTH];
    logic [31:0] dst_syns    [DST_DEPTH];
    logic [31:0] dst_acks    [DST_DEPTH];
    logic [10:0] flagged_total = '0;

    t_verdict    pending_verdicts[$];
    t_dir_row    dir_rows[$];
    logic [31:0] src_pool[SRC_POOL];
    logic [31:0] dst_pool[DST_POOL];
    logic [62:0] now = 63'd10_000;
    int unsigned dt_max = 10;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          stall_req = 1'b0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    function automatic int unsigned slot_for(logic [31:0] a, int unsigned depth);
        logic [31:0] h;
        h = a * frl_pkg::HASH_MULT;
        return (h >> 16) % depth;
    endfunction

    function automatic logic [31:0] clash_with(logic [31:0] a, int unsigned depth);
        logic [31:0] c;
        do begin
            c = $urandom;
        end while (c == a || slot_for(c, depth) != slot_for(a, depth));
        return c;
    endfunction

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic t_verdict judge_packet(t_packet p);
        t_verdict    v;
        int unsigned di;
        int unsigned si;
        logic [31:0] base;
        logic [39:0] bar;
        v = '0;
        di = slot_for(p.dst, DST_DEPTH);
        if (!dst_used[di] && (p.kind == frl_pkg::KIND_SYN || p.kind == frl_pkg::KIND_SYNACK))
        begin
            dst_used[di] = 1'b1;
            dst_owner[di] = p.dst;
            dst_syns[di] = '0;
            dst_acks[di] = '0;
        end
        if (dst_used[di]) begin
            if (dst_owner[di] == p.dst) begin
                if (p.kind == frl_pkg::KIND_SYN) begin
                    dst_syns[di] = bump(dst_syns[di]);
                end else if (p.kind == frl_pkg::KIND_SYNACK) begin
                    dst_acks[di] = bump(dst_acks[di]);
                end
                v.syn = dst_syns[di];
                v.ack = dst_acks[di];
                base = (v.ack == 32'd0) ? 32'd1 : v.ack;
                bar = 40'(lim_ratio) * 40'(base);
                v.flood = (40'(v.syn) > bar) && (v.syn > lim_min);
            end else begin
                v.untracked = 1'b1;
            end
        end
        si = slot_for(p.src, SRC_DEPTH);
        if (!src_used[si]) begin
            src_used[si] = 1'b1;
            src_owner[si] = p.src;
            src_hits[si] = 32'd1;
            src_since[si] = p.ts;
        end else if (src_owner[si] != p.src) begin
            v.untracked = 1'b1;
        end else if ((p.ts < src_since[si]) || ((p.ts - src_since[si]) < lim_window)) begin
            src_hits[si] = bump(src_hits[si]);
            if (src_hits[si] > lim_rate) begin
                v.over = 1'b1;
                if (!src_flagged[si]) begin
                    src_flagged[si] = 1'b1;
                    v.fresh = 1'b1;
                    if (flagged_total < frl_pkg::ATT_MAX) begin
                        flagged_total = flagged_total + 11'd1;
                    end
                end
            end
        end else begin
            src_hits[si] = 32'd1;
            src_since[si] = p.ts;
        end
        v.total = flagged_total;
        return v;
    endfunction

    function automatic t_packet pk(logic [31:0] src, logic [31:0] dst, logic [62:0] ts,
                                   logic [1:0] kind);
        t_packet p;
        p.src = src;
        p.dst = dst;
        p.ts = ts;
        p.kind = kind;
        return p;
    endfunction

    function automatic t_verdict vd(logic over, logic fresh, logic [10:0] total, logic flood,
                                    logic [31:0] syn, logic [31:0] ack, logic untracked);
        t_verdict v;
        v.over = over;
        v.fresh = fresh;
        v.total = total;
        v.flood = flood;
        v.syn = syn;
        v.ack = ack;
        v.untracked = untracked;
        return v;
    endfunction

    task automatic add_row(input t_packet p, input bit literal, input t_verdict want);
        t_dir_row r;
        r.pkt = p;
        r.literal = literal;
        r.want = want;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    function automatic t_packet make_packet();
        t_packet     p;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) begin
            p.src = $urandom;
            p.dst = $urandom;
            p.ts = 63'({$urandom, $urandom});
            p.kind = 2'($urandom_range(3));
        end else begin
            p.src = src_pool[$urandom_range(SRC_POOL - 1)];
            p.dst = dst_pool[$urandom_range(DST_POOL - 1)];
            r = $urandom_range(99);
            p.kind = (r < 50) ? frl_pkg::KIND_SYN : (r < 65) ? frl_pkg::KIND_SYNACK :
                     (r < 90) ? KIND_ACK : KIND_OTHER;
            if ($urandom_range(99) < 8) begin
                p.ts = now - 63'($urandom_range(dt_max));
            end else begin
                now = now + 63'($urandom_range(dt_max));
                p.ts = now;
            end
        end
        return p;
    endfunction

    task automatic offer_packet(input t_packet p, input bit literal, input t_verdict want);
        t_verdict v;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do begin
                @(posedge clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, p.ts, p.dst, p.src};
        s_tuser <= p.kind;
        do begin
            @(posedge clk);
        end while (!s_tready);
        v = judge_packet(p);
        pending_verdicts.insert(pending_verdicts.size(), literal ? want : v);
    endtask

    task automatic wait_drained();
        while (pending_verdicts.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [frl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [frl_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic load_limits(input logic [31:0] rate, input logic [62:0] window,
                               input logic [7:0] ratio, input logic [31:0] minimum);
        write_reg(frl_pkg::REG_RATE_LIMIT, 63'(rate));
        write_reg(frl_pkg::REG_TIME_WINDOW, window);
        write_reg(frl_pkg::REG_SYN_RATIO, 63'(ratio));
        write_reg(frl_pkg::REG_SYN_MINIMUM, 63'(minimum));
        cfg_we <= 1'b0;
        lim_rate = rate;
        lim_window = window;
        lim_ratio = ratio;
        lim_min = minimum;
    endtask

    task automatic run_phase(input logic [31:0] rate, input logic [62:0] window,
                             input logic [7:0] ratio, input logic [31:0] minimum,
                             input int unsigned dt, input int unsigned send_pct,
                             input int unsigned recv_pct, input int unsigned count,
                             input bit hold);
        wait_drained();
        load_limits(rate, window, ratio, minimum);
        dt_max = dt;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        if (hold) begin
            stall_req = 1'b1;
        end
        repeat (count) begin
            offer_packet(make_packet(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic take_result(input logic [79:0] d);
        t_verdict want;
        if (pending_verdicts.size() == 0) begin
            $error("result beat with no expectation waiting");
            fail_count++;
        end else begin
            want = pending_verdicts.pop_front();
            compare_field("over_limit", 32'(want.over), 32'(d[0]));
            compare_field("new_attacker", 32'(want.fresh), 32'(d[1]));
            compare_field("attacker_total", 32'(want.total), 32'(d[12:2]));
            compare_field("syn_flood", 32'(want.flood), 32'(d[13]));
            compare_field("syn_total", want.syn, d[45:14]);
            compare_field("synack_total", want.ack, d[77:46]);
            compare_field("untracked", 32'(want.untracked), 32'(d[78]));
        end
    endtask

    initial begin
        int unsigned hold_left;
        bit          hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                take_result(m_tdata);
            end
            if (stall_req && !hold_seen) begin
                hold_left = HOLD_CYCLES;
                hold_seen = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("flow_rate_limit_syn_flood_detector_unit regression: fail");
            $finish;
        end
    end

    initial begin
        logic [31:0] a_src;
        logic [31:0] c_src;
        logic [31:0] d_dst;
        logic [31:0] e_dst;
        logic [62:0] w;
        int unsigned split;
        do begin
            a_src = $urandom;
        end while (slot_for(a_src, SRC_DEPTH) == slot_for(32'h0, SRC_DEPTH) ||
                   slot_for(a_src, SRC_DEPTH) == slot_for(32'hFFFF_FFFF, SRC_DEPTH));
        do begin
            d_dst = $urandom;
        end while (slot_for(d_dst, DST_DEPTH) == slot_for(32'h0, DST_DEPTH) ||
                   slot_for(d_dst, DST_DEPTH) == slot_for(32'hFFFF_FFFF, DST_DEPTH));
        c_src = clash_with(a_src, SRC_DEPTH);
        e_dst = clash_with(d_dst, DST_DEPTH);
        src_pool[0] = a_src;
        src_pool[1] = c_src;
        for (int i = 2; i < SRC_POOL; i++) begin
            src_pool[i] = $urandom;
        end
        dst_pool[0] = d_dst;
        dst_pool[1] = e_dst;
        for (int i = 2; i < DST_POOL; i++) begin
            dst_pool[i] = $urandom;
        end

        add_row(pk(a_src, d_dst, 63'd0, frl_pkg::KIND_SYN), 1'b1,
                vd(1'b0, 1'b0, 11'd0, 1'b0, 32'd1, 32'd0, 1'b0));
        add_row(pk(a_src, d_dst, 63'd5, frl_pkg::KIND_SYNACK), 1'b1,
                vd(1'b0, 1'b0, 11'd0, 1'b0, 32'd1, 32'd1, 1'b0));
        add_row(pk(32'hFFFF_FFFF, 32'h0, TS_MAX, KIND_ACK), 1'b1,
                vd(1'b0, 1'b0, 11'd0, 1'b0, 32'd0, 32'd0, 1'b0));
        add_row(pk(32'h0, 32'hFFFF_FFFF, TS_MAX, KIND_OTHER), 1'b1,
                vd(1'b0, 1'b0, 11'd0, 1'b0, 32'd0, 32'd0, 1'b0));
        add_row(pk(c_src, d_dst, 63'd10, frl_pkg::KIND_SYN), 1'b1,
                vd(1'b0, 1'b0, 11'd0, 1'b0, 32'd2, 32'd1, 1'b1));
        add_row(pk(a_src, e_dst, 63'd20, frl_pkg::KIND_SYN), 1'b1,
                vd(1'b0, 1'b0, 11'd0, 1'b0, 32'd0, 32'd0, 1'b1));
        add_row(pk(a_src, e_dst, 63'd21, KIND_ACK), 1'b1,
                vd(1'b0, 1'b0, 11'd0, 1'b0, 32'd0, 32'd0, 1'b1));
        add_row(pk(a_src, d_dst, 63'd30, KIND_OTHER), 1'b1,
                vd(1'b0, 1'b0, 11'd0, 1'b0, 32'd2, 32'd1, 1'b0));
        add_row(pk(32'hFFFF_FFFF, 32'h0, 63'd0, frl_pkg::KIND_SYN), 1'b1,
                vd(1'b0, 1'b0, 11'd0, 1'b0, 32'd1, 32'd0, 1'b0));
        split = dir_rows.size();
        add_row(pk(a_src, d_dst, 63'd1000, frl_pkg::KIND_SYN), 1'b0, '0);
        add_row(pk(a_src, d_dst, 63'd1050, frl_pkg::KIND_SYN), 1'b0, '0);
        add_row(pk(a_src, d_dst, 63'd1060, KIND_ACK), 1'b0, '0);
        add_row(pk(a_src, d_dst, 63'd500, KIND_OTHER), 1'b0, '0);
        add_row(pk(a_src, d_dst, 63'd1150, frl_pkg::KIND_SYNACK), 1'b0, '0);
        add_row(pk(a_src, d_dst, 63'd1249, frl_pkg::KIND_SYN), 1'b0, '0);
        add_row(pk(c_src, e_dst, 63'd1300, frl_pkg::KIND_SYNACK), 1'b0, '0);
        add_row(pk(32'h5A5A_5A5A, 32'hA5A5_A5A5, 63'h2AAA_AAAA_AAAA_AAAA,
                   frl_pkg::KIND_SYN), 1'b0, '0);
        add_row(pk(32'hA5A5_A5A5, 32'h5A5A_5A5A, 63'h5555_5555_5555_5555,
                   frl_pkg::KIND_SYNACK), 1'b0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < dir_rows.size(); i++) begin
            if (i == split) begin
                s_tvalid <= 1'b0;
                wait_drained();
                // Limit of one packet per short window, and a zero ratio.
                load_limits(32'd1, 63'd100, 8'd0, 32'd0);
            end
            offer_packet(dir_rows[i].pkt, dir_rows[i].literal, dir_rows[i].want);
        end
        s_tvalid <= 1'b0;

        run_phase(32'd4, 63'd400, 8'd2, 32'd3, 10, 0, 0, 90, 1'b0);
        run_phase(32'd0, 63'd0, 8'd255, 32'd0, 5, 51, 0, 90, 1'b0);
        run_phase(32'hFFFF_FFFF, TS_MAX, 8'd1, 32'hFFFF_FFFF, 1000, 0, 51, 90, 1'b0);
        w = 63'($urandom_range(200, 2000));
        run_phase(32'($urandom_range(2, 8)), w, 8'($urandom_range(1, 4)),
                  32'($urandom_range(0, 6)), int'(w) / 20, 7, 7, 90, 1'b0);
        run_phase(32'd3, 63'd1000, 8'd0, 32'd1, 50, 0, 0, 90, 1'b1);
        run_phase(32'($urandom_range(1, 6)), 63'({$urandom, $urandom}),
                  8'($urandom_range(255)), 32'($urandom_range(20)),
                  $urandom_range(1, 1000), 51, 51, 90, 1'b0);

        recv_stall_pct = 0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("flow_rate_limit_syn_flood_detector_unit regression: pass");
        end else begin
            $display("flow_rate_limit_syn_flood_detector_unit regression: fail");
        end
        $finish;
    end

endmodule
